@@ rtl/pbrf_pkg.sv @@
// Types and constants shared by the packet blocklist filter files.
package pbrf_pkg;

    localparam int PORT_W     = 16;
    localparam int PORT_BIT_W = 5;
    localparam int PORT_ROW_W = PORT_W - PORT_BIT_W;
    localparam int PORT_ROWS  = 1 << PORT_ROW_W;
    localparam int PORT_WORD  = 1 << PORT_BIT_W;

    localparam logic [2:0] OP_LOOKUP   = 3'd0;
    localparam logic [2:0] OP_ADD_IP   = 3'd1;
    localparam logic [2:0] OP_DEL_IP   = 3'd2;
    localparam logic [2:0] OP_ADD_PORT = 3'd3;
    localparam logic [2:0] OP_DEL_PORT = 3'd4;
    localparam logic [2:0] OP_ADD_APP  = 3'd5;
    localparam logic [2:0] OP_DEL_APP  = 3'd6;
    localparam logic [2:0] OP_CLEAR    = 3'd7;

    localparam logic [1:0] RSN_NONE = 2'd0;
    localparam logic [1:0] RSN_ADDR = 2'd1;
    localparam logic [1:0] RSN_PORT = 2'd2;
    localparam logic [1:0] RSN_APP  = 2'd3;

    typedef struct packed {
        logic [2:0]        op;
        logic [31:0]       ip_address;
        logic [PORT_W-1:0] port_number;
        logic [4:0]        app_id;
    } t_item;

    typedef struct packed {
        logic       blocked;
        logic [1:0] reason;
        logic       table_full;
        logic [4:0] ip_rule_count;
    } t_result;

endpackage

@@ rtl/pbrf_ram.sv @@
// Generic simple dual-port RAM with registered read.
module pbrf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/packet_block_rule_filter_unit.sv @@
// Top level of the packet blocklist filter: sequencer around address and port memories.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------
//  command  | in        | start high, busy low      | i_item  (t_item)
//  result   | out       | o_done strobe, one cycle  | o_result (t_result)
//
// Lookup, address add and address remove scan the address memory through its read port,
// one entry per cycle, before o_done. Port edits read the bitmap row on accept and write
// it back in S_PORT_WR; application edits update the mask in S_FINISH. Clear all sweeps
// the port bitmap memory, one 32-bit row per cycle, also clearing the address entries.
// After reset the same clearing pass runs with busy high and no result. Results are never
// held off; a new word may be accepted in the cycle o_done is high.
module packet_block_rule_filter_unit
    import pbrf_pkg::*;
#(
    parameter int IP_ENTRIES = 16,
    parameter int APP_TYPES  = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    output logic    busy,
    input  t_item   i_item,
    output logic    o_done,
    output t_result o_result
);

    localparam int IW  = (IP_ENTRIES > 1) ? $clog2(IP_ENTRIES) : 1;
    localparam int CW  = $clog2(IP_ENTRIES + 1);
    localparam int AIW = $clog2(APP_TYPES);

    localparam logic [2:0] S_CLEAR   = 3'd0;
    localparam logic [2:0] S_IDLE    = 3'd1;
    localparam logic [2:0] S_SEARCH  = 3'd2;
    localparam logic [2:0] S_LAST    = 3'd3;
    localparam logic [2:0] S_FINISH  = 3'd4;
    localparam logic [2:0] S_PORT_WR = 3'd5;

    logic [2:0]            r_state, n_state;
    t_item                 r_item, n_item;
    logic [PORT_ROW_W-1:0] r_idx, n_idx;
    logic                  r_cmp_vld, n_cmp_vld;
    logic [IW-1:0]         r_cmp_idx, n_cmp_idx;
    logic                  r_hit, n_hit;
    logic [IW-1:0]         r_hit_idx, n_hit_idx;
    logic                  r_free, n_free;
    logic [IW-1:0]         r_free_idx, n_free_idx;
    logic [CW-1:0]         r_count, n_count;
    logic [APP_TYPES-1:0]  r_app_mask, n_app_mask;
    logic                  r_clr_rpt, n_clr_rpt;
    logic                  r_done, n_done;
    t_result               r_result, n_result;

    logic                  a_we, a_re;
    logic [IW-1:0]         a_waddr;
    logic [32:0]           a_wdata, a_rdata;
    logic                  p_we, p_re;
    logic [PORT_ROW_W-1:0] p_waddr, p_raddr;
    logic [PORT_WORD-1:0]  p_wdata, p_rdata;

    logic [CW-1:0]         w_cnt_new;
    logic [31:0]           w_cnt_ext;
    logic [31:0]           w_app_ext;
    logic                  w_app_ok;
    logic [AIW-1:0]        w_app_idx;
    logic                  w_app_hit;
    logic                  w_port_hit;
    logic                  w_accept;

    pbrf_ram #(
        .WIDTH (33),
        .DEPTH (IP_ENTRIES)
    ) u_addr_ram (
        .i_clk   (i_clk),
        .i_we    (a_we),
        .i_waddr (a_waddr),
        .i_wdata (a_wdata),
        .i_re    (a_re),
        .i_raddr (r_idx[IW-1:0]),
        .o_rdata (a_rdata)
    );

    pbrf_ram #(
        .WIDTH (PORT_WORD),
        .DEPTH (PORT_ROWS)
    ) u_port_ram (
        .i_clk   (i_clk),
        .i_we    (p_we),
        .i_waddr (p_waddr),
        .i_wdata (p_wdata),
        .i_re    (p_re),
        .i_raddr (p_raddr),
        .o_rdata (p_rdata)
    );

    assign w_accept   = start && (r_state == S_IDLE);
    assign busy       = (r_state != S_IDLE);
    assign a_re       = (r_state == S_SEARCH);
    assign p_re       = w_accept;
    assign p_raddr    = i_item.port_number[PORT_W-1:PORT_BIT_W];
    assign w_app_ext  = 32'(r_item.app_id);
    assign w_app_ok   = (w_app_ext < 32'(APP_TYPES));
    assign w_app_idx  = w_app_ext[AIW-1:0];
    assign w_app_hit  = w_app_ok ? r_app_mask[w_app_idx] : 1'b0;
    assign w_port_hit = p_rdata[r_item.port_number[PORT_BIT_W-1:0]];
    assign w_cnt_ext  = 32'(w_cnt_new);

    always_comb begin
        n_state    = r_state;
        n_item     = r_item;
        n_idx      = r_idx;
        n_cmp_vld  = r_cmp_vld;
        n_cmp_idx  = r_cmp_idx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_free     = r_free;
        n_free_idx = r_free_idx;
        n_count    = r_count;
        n_app_mask = r_app_mask;
        n_clr_rpt  = r_clr_rpt;
        n_done     = 1'b0;
        n_result   = r_result;
        w_cnt_new  = r_count;
        a_we       = 1'b0;
        a_waddr    = r_free_idx;
        a_wdata    = '0;
        p_we       = 1'b0;
        p_waddr    = r_item.port_number[PORT_W-1:PORT_BIT_W];
        p_wdata    = p_rdata;

        if (r_cmp_vld) begin
            if (a_rdata[32] && (a_rdata[31:0] == r_item.ip_address) && !r_hit) begin
                n_hit     = 1'b1;
                n_hit_idx = r_cmp_idx;
            end
            if (!a_rdata[32] && !r_free) begin
                n_free     = 1'b1;
                n_free_idx = r_cmp_idx;
            end
        end

        case (r_state)
            S_CLEAR: begin
                p_we    = 1'b1;
                p_waddr = r_idx;
                p_wdata = '0;
                if (r_idx < PORT_ROW_W'(IP_ENTRIES)) begin
                    a_we    = 1'b1;
                    a_waddr = r_idx[IW-1:0];
                end
                n_idx = r_idx + 1'b1;
                if (r_idx == PORT_ROW_W'(PORT_ROWS - 1)) begin
                    n_state  = S_IDLE;
                    n_done   = r_clr_rpt;
                    n_result = '0;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_item = i_item;
                    n_idx  = '0;
                    n_hit  = 1'b0;
                    n_free = 1'b0;
                    case (i_item.op)
                        OP_LOOKUP, OP_ADD_IP, OP_DEL_IP: n_state = S_SEARCH;
                        OP_ADD_PORT, OP_DEL_PORT:        n_state = S_PORT_WR;
                        OP_ADD_APP, OP_DEL_APP:          n_state = S_FINISH;
                        default: begin
                            n_state    = S_CLEAR;
                            n_clr_rpt  = 1'b1;
                            n_count    = '0;
                            n_app_mask = '0;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                n_cmp_vld = 1'b1;
                n_cmp_idx = r_idx[IW-1:0];
                n_idx     = r_idx + 1'b1;
                if (r_idx == PORT_ROW_W'(IP_ENTRIES - 1)) begin
                    n_state = S_LAST;
                end
            end
            S_LAST: begin
                n_cmp_vld = 1'b0;
                n_state   = S_FINISH;
            end
            S_FINISH: begin
                n_done   = 1'b1;
                n_state  = S_IDLE;
                n_result = '0;
                case (r_item.op)
                    OP_LOOKUP: begin
                        if (r_hit) begin
                            n_result.reason = RSN_ADDR;
                        end else if (w_port_hit) begin
                            n_result.reason = RSN_PORT;
                        end else if (w_app_hit) begin
                            n_result.reason = RSN_APP;
                        end
                        n_result.blocked = r_hit || w_port_hit || w_app_hit;
                    end
                    OP_ADD_IP: begin
                        if (!r_hit) begin
                            if (r_free) begin
                                a_we      = 1'b1;
                                a_waddr   = r_free_idx;
                                a_wdata   = {1'b1, r_item.ip_address};
                                w_cnt_new = r_count + 1'b1;
                            end else begin
                                n_result.table_full = 1'b1;
                            end
                        end
                    end
                    OP_DEL_IP: begin
                        if (r_hit) begin
                            a_we      = 1'b1;
                            a_waddr   = r_hit_idx;
                            a_wdata   = {1'b0, r_item.ip_address};
                            w_cnt_new = r_count - 1'b1;
                        end
                    end
                    OP_ADD_APP: begin
                        if (w_app_ok) begin
                            n_app_mask[w_app_idx] = 1'b1;
                        end
                    end
                    OP_DEL_APP: begin
                        if (w_app_ok) begin
                            n_app_mask[w_app_idx] = 1'b0;
                        end
                    end
                    default: begin
                    end
                endcase
                n_count                = w_cnt_new;
                n_result.ip_rule_count = w_cnt_ext[4:0];
            end
            S_PORT_WR: begin
                p_we = 1'b1;
                p_wdata[r_item.port_number[PORT_BIT_W-1:0]] = (r_item.op == OP_ADD_PORT);
                n_done                 = 1'b1;
                n_state                = S_IDLE;
                n_result               = '0;
                n_result.ip_rule_count = w_cnt_ext[4:0];
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_idx      <= '0;
            r_cmp_vld  <= 1'b0;
            r_count    <= '0;
            r_app_mask <= '0;
            r_clr_rpt  <= 1'b0;
            r_done     <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_cmp_vld  <= n_cmp_vld;
            r_count    <= n_count;
            r_app_mask <= n_app_mask;
            r_clr_rpt  <= n_clr_rpt;
            r_done     <= n_done;
        end
    end

    always_ff @(posedge i_clk) begin
        r_item     <= n_item;
        r_cmp_idx  <= n_cmp_idx;
        r_hit      <= n_hit;
        r_hit_idx  <= n_hit_idx;
        r_free     <= n_free;
        r_free_idx <= n_free_idx;
        r_result   <= n_result;
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

@@ rtl/pbrf_chk.sv @@
// Port-level checker for the packet blocklist filter, bound to the top level.
module pbrf_chk
    import pbrf_pkg::*;
(
    input logic    i_clk,
    input logic    i_rst_n,
    input logic    start,
    input logic    busy,
    input t_item   i_item,
    input logic    o_done,
    input t_result o_result
);

    a_accept_busy : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after an accepted word");

    a_done_gap : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done)
        else $error("result strobes in back-to-back cycles");

    a_blocked_reason : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_result.blocked == (o_result.reason != RSN_NONE)))
        else $error("blocked flag disagrees with reason");

    a_full_not_blocked : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_result.table_full) |-> !o_result.blocked)
        else $error("table full reported on a lookup result");

endmodule

bind packet_block_rule_filter_unit pbrf_chk u_pbrf_chk (.*);
